/* rtl/sts_pkg.sv */
// shared types and constants for the sorted table binary search block
// no dependencies; used by every module under rtl except sts_ram

package sts_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    // input item fields
    localparam int OP_W      = 2;
    localparam int SLOT_W    = 10;
    localparam int VALUE_W   = 32;
    localparam int OP_LSB    = 0;
    localparam int SLOT_LSB  = OP_LSB + OP_W;
    localparam int VALUE_LSB = SLOT_LSB + SLOT_W;
    localparam int S_TDATA_W = 48;

    // result item fields
    localparam int COUNT_W   = 11;
    localparam int POS_W     = 11;
    localparam int PROBE_W   = 4;
    localparam int M_TDATA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_EXACT = 2'd1,
        OP_LOWER = 2'd2
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic load_we;
        logic capture;
        logic start;
        logic probe;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic last;
        logic out_free;
    } status_t;

endpackage

/* rtl/sts_ram.sv */
// generic simple dual-port ram, one write port and one registered read port
// no dependencies

module sts_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/sts_ctrl.sv */
// search controller: one-hot state machine sequencing load, setup, probe and result steps
// depends on sts_pkg for the command and status structs and operation codes

module sts_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [sts_pkg::OP_W-1:0] operation,
    input  sts_pkg::status_t         status,
    output sts_pkg::cmd_t            cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_PROBE = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (operation)
                        sts_pkg::OP_LOAD: begin
                            cmd.load_we = 1'b1;
                        end
                        sts_pkg::OP_EXACT, sts_pkg::OP_LOWER: begin
                            cmd.capture = 1'b1;
                            state_next  = S_START;
                        end
                        default: begin
                            // unused code, dropped
                        end
                    endcase
                end
            end
            S_START: begin
                cmd.start  = 1'b1;
                state_next = status.empty ? S_DONE : S_PROBE;
            end
            S_PROBE: begin
                cmd.probe = 1'b1;
                if (status.last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/sts_datapath.sv */
// search datapath: count register, table ram, bound registers, probe compare
// and result register; depends on sts_pkg and sts_ram

module sts_datapath #(
    parameter int TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sts_pkg::COUNT_W-1:0]   cfg_wr_data,
    input  logic [sts_pkg::S_TDATA_W-1:0] s_tdata,
    input  sts_pkg::cmd_t                 cmd,
    output sts_pkg::status_t              status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sts_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int POS_W  = sts_pkg::POS_W;

    logic [sts_pkg::COUNT_W-1:0]   element_count_reg;
    logic [POS_W-1:0]              eff_count;

    logic [sts_pkg::OP_W-1:0]      in_op;
    logic [sts_pkg::SLOT_W-1:0]    in_slot;
    logic [sts_pkg::VALUE_W-1:0]   in_value;
    logic                          slot_ok;

    logic [ADDR_W-1:0]             ram_raddr;
    logic [sts_pkg::VALUE_W-1:0]   ram_rdata;

    logic signed [sts_pkg::VALUE_W-1:0] key_reg;
    logic                          mode_exact_reg;
    logic [POS_W-1:0]              lo_reg, lo_next;
    logic [POS_W-1:0]              hi1_reg, hi1_next;   // exclusive upper bound
    logic [POS_W-1:0]              mid_reg, mid_next;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic                          found_reg, found_next;
    logic [sts_pkg::PROBE_W-1:0]   probes_reg;
    logic [POS_W-1:0]              mid0;
    logic [POS_W:0]                mid_sum;
    logic                          entry_lt, entry_eq, hit;
    logic                          found_out;

    logic                          m_tvalid_reg;
    logic [sts_pkg::M_TDATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            element_count_reg <= '0;
        end else if (cfg_wr_en) begin
            element_count_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        if (32'(element_count_reg) > TABLE_DEPTH) begin
            eff_count = POS_W'(TABLE_DEPTH);
        end else begin
            eff_count = element_count_reg;
        end
    end

    assign in_op    = s_tdata[sts_pkg::OP_LSB +: sts_pkg::OP_W];
    assign in_slot  = s_tdata[sts_pkg::SLOT_LSB +: sts_pkg::SLOT_W];
    assign in_value = s_tdata[sts_pkg::VALUE_LSB +: sts_pkg::VALUE_W];
    assign slot_ok  = (32'(in_slot) < TABLE_DEPTH);

    // probe step: compare the entry at mid_reg with the key and narrow the range
    always_comb begin
        entry_lt   = ($signed(ram_rdata) < key_reg);
        entry_eq   = ($signed(ram_rdata) == key_reg);
        lo_next    = lo_reg;
        hi1_next   = hi1_reg;
        pos_next   = pos_reg;
        found_next = found_reg;
        hit        = 1'b0;
        if (mode_exact_reg) begin
            if (entry_eq) begin
                found_next = 1'b1;
                pos_next   = mid_reg;
                hit        = 1'b1;
            end else if (entry_lt) begin
                lo_next = mid_reg + POS_W'(1);
            end else begin
                hi1_next = mid_reg;
            end
        end else begin
            if (entry_lt) begin
                lo_next = mid_reg + POS_W'(1);
            end else begin
                pos_next = mid_reg;
                hi1_next = mid_reg;
            end
        end
        mid_sum  = {1'b0, lo_next} + {1'b0, hi1_next} - (POS_W+1)'(1);
        mid_next = mid_sum[POS_W:1];
    end

    assign mid0 = (eff_count - POS_W'(1)) >> 1;

    always_comb begin
        if (cmd.start) begin
            ram_raddr = ADDR_W'(mid0);
        end else if (cmd.probe) begin
            ram_raddr = ADDR_W'(mid_next);
        end else begin
            ram_raddr = ADDR_W'(mid_reg);
        end
    end

    sts_ram #(
        .DATA_W (sts_pkg::VALUE_W),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .aclk  (aclk),
        .we    (cmd.load_we && slot_ok),
        .waddr (ADDR_W'(in_slot)),
        .wdata (in_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            key_reg        <= $signed(in_value);
            mode_exact_reg <= (in_op == sts_pkg::OP_EXACT);
        end
        if (cmd.start) begin
            lo_reg     <= '0;
            hi1_reg    <= eff_count;
            mid_reg    <= mid0;
            pos_reg    <= eff_count;
            found_reg  <= 1'b0;
            probes_reg <= '0;
        end else if (cmd.probe) begin
            lo_reg    <= lo_next;
            hi1_reg   <= hi1_next;
            mid_reg   <= mid_next;
            pos_reg   <= pos_next;
            found_reg <= found_next;
            if (probes_reg != '1) begin
                probes_reg <= probes_reg + sts_pkg::PROBE_W'(1);
            end
        end
    end

    assign status.empty    = (eff_count == '0);
    assign status.last     = hit || (lo_next >= hi1_next);
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign found_out = mode_exact_reg ? found_reg : (pos_reg < eff_count);

    // result register, holds a finished transfer until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {probes_reg, pos_reg, found_out};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* rtl/sorted_table_binary_search.sv */
// sorted table binary search, top level; depends on sts_pkg, sts_ctrl, sts_datapath
// a load is written into the table on accept; the controller stays idle. a search has a setup
// state, one probe state per table read via the registered ram read port (probes <= log2(depth) + 1,
// at most 11 at depth 1024) and a result state that waits for a free result register, then idles.
// the result register frees the output side, so a new item can enter while a result waits.
// aresetn (synchronous, active low) clears element_count and the control state; table is not cleared.

module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sts_pkg::COUNT_W-1:0]   cfg_wr_data,   // element_count
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sts_pkg::S_TDATA_W-1:0] s_tdata,       // operation, slot, value, 4'b0
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sts_pkg::M_TDATA_W-1:0] m_tdata        // found, position, probes
);

    sts_pkg::cmd_t    cmd;
    sts_pkg::status_t status;

    sts_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .operation (s_tdata[sts_pkg::OP_LSB +: sts_pkg::OP_W]),
        .status    (status),
        .cmd       (cmd)
    );

    sts_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
